### design/dlook_pkg.sv
// ----------------------------------------------------------------------------
// dlook_pkg: shared types and codes for the LOOK disk request scheduler
// Request record, command and result beats, status codes and search classes.
// ----------------------------------------------------------------------------
package dlook_pkg;

  typedef enum logic [2:0] {
    ST_DISPATCH = 3'd0,
    ST_QUEUED   = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_NEXT     = 3'd3,
    ST_IDLE     = 3'd4
  } status_t;

  typedef enum logic {
    OP_ARRIVE   = 1'b0,
    OP_COMPLETE = 1'b1
  } op_t;

  typedef struct packed {
    logic [15:0] req_tag;
    logic [31:0] arrival_time;
    logic [15:0] cylinder;
    logic [31:0] block_address;
    logic [15:0] owner_pid;
  } request_t;

  // One command beat on the input channel.
  typedef struct packed {
    op_t         op;
    logic [15:0] in_request_id;
    logic [31:0] in_arrival_time;
    logic [15:0] in_cylinder;
    logic [31:0] in_block_address;
    logic [15:0] in_process_id;
    logic [15:0] head_cylinder;
    logic        scan_up;
  } cmd_t;

  // One result beat on the output channel.
  typedef struct packed {
    status_t     status;
    logic [15:0] out_request_id;
    logic [31:0] out_arrival_time;
    logic [15:0] out_cylinder;
    logic [31:0] out_block_address;
    logic [15:0] out_process_id;
  } result_t;

  // Search classes, ordered so that a lower value wins.
  typedef enum logic [1:0] {
    CL_HEAD  = 2'd0,
    CL_AHEAD = 2'd1,
    CL_OTHER = 2'd2,
    CL_NONE  = 2'd3
  } class_t;

endpackage

### design/dlook_if.sv
// ----------------------------------------------------------------------------
// dlook_if: valid/ready channel carrying one payload beat
// Source drives valid and payload, sink drives ready.
// ----------------------------------------------------------------------------
interface dlook_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### design/dlook_cell.sv
// ----------------------------------------------------------------------------
// dlook_cell: one slot of the pending request table
// Holds one entry and compares it against the best candidate handed in from
// the previous cell, registering the running best for the next one.
// ----------------------------------------------------------------------------
module dlook_cell #(
  parameter int IDX_W = 4
) (
  input  logic                  clk,
  input  logic                  load,
  input  dlook_pkg::request_t   load_data,
  input  logic                  shift,
  input  dlook_pkg::request_t   shift_data,
  input  logic                  occupied,
  input  logic [IDX_W-1:0]      my_index,
  input  logic [15:0]           head,
  input  logic                  up,
  input  dlook_pkg::class_t     in_class,
  input  logic [31:0]           in_key,
  input  logic [IDX_W-1:0]      in_index,
  output dlook_pkg::class_t     out_class,
  output logic [31:0]           out_key,
  output logic [IDX_W-1:0]      out_index,
  output dlook_pkg::request_t   entry
);

  dlook_pkg::class_t my_class;
  logic [31:0]       my_key;
  logic              better;

  // Entry storage: written on insert, or from the neighbor on removal.
  always_ff @(posedge clk) begin
    if (load) begin
      entry <= load_data;
    end else if (shift) begin
      entry <= shift_data;
    end
  end

  // Classify this entry and form a key where smaller is better.
  always_comb begin
    my_class = dlook_pkg::CL_NONE;
    my_key   = '0;
    if (occupied) begin
      if (entry.cylinder == head) begin
        my_class = dlook_pkg::CL_HEAD;
        my_key   = entry.arrival_time;
      end else if (up == (entry.cylinder > head)) begin
        my_class = dlook_pkg::CL_AHEAD;
        my_key   = up ? {16'd0, entry.cylinder} : {16'd0, ~entry.cylinder};
      end else begin
        my_class = dlook_pkg::CL_OTHER;
        my_key   = up ? {16'd0, ~entry.cylinder} : {16'd0, entry.cylinder};
      end
    end
  end

  // Strict compare keeps the earliest inserted entry on a tie.
  always_comb begin
    better = (my_class < in_class) || (my_class == in_class && my_key < in_key);
  end

  // The running best moves one cell per cycle.
  always_ff @(posedge clk) begin
    if (better) begin
      out_class <= my_class;
      out_key   <= my_key;
      out_index <= my_index;
    end else begin
      out_class <= in_class;
      out_key   <= in_key;
      out_index <= in_index;
    end
  end

endmodule

### design/disk_request_look_scheduler.sv
// ----------------------------------------------------------------------------
// disk_request_look_scheduler: LOOK scheduler over a row of table cells
// ----------------------------------------------------------------------------
// An arrival, or a completion on an empty table, is accepted and its result
// sits in the output register on the next cycle. A completion with queued
// work registers the head and direction, then lets the best-candidate beat
// ripple through the QUEUE_DEPTH cells, one registered cell per cycle, and
// then, in the remove state, shifts the entries behind the chosen one down
// and loads the result. Only one beat is in flight: a new beat is accepted
// only when the sequencer is idle and the output register is empty, that
// is, in the cycle after the previous result has been taken.
// ----------------------------------------------------------------------------
module disk_request_look_scheduler #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  dlook_if.sink   in_ch,
  dlook_if.source out_ch
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_REMOVE
  } state_t;

  state_t                state;
  logic [CNT_W-1:0]      entry_count;
  logic                  disk_busy;
  logic [IDX_W-1:0]      step;
  logic [15:0]           head;
  logic                  up;
  logic [IDX_W-1:0]      best_index;
  dlook_pkg::request_t   in_req;
  dlook_pkg::result_t    res_next;

  dlook_pkg::request_t   entries [QUEUE_DEPTH];
  dlook_pkg::class_t     cls_o   [QUEUE_DEPTH];
  logic [31:0]           key_o   [QUEUE_DEPTH];
  logic [IDX_W-1:0]      idx_o   [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] load_en;
  logic [QUEUE_DEPTH-1:0] shift_en;

  logic accept;

  assign in_req = '{req_tag: in_ch.payload.in_request_id,
                    arrival_time: in_ch.payload.in_arrival_time,
                    cylinder: in_ch.payload.in_cylinder,
                    block_address: in_ch.payload.in_block_address,
                    owner_pid: in_ch.payload.in_process_id};

  assign in_ch.ready = (state == S_IDLE) && !out_ch.valid;
  assign accept      = in_ch.valid && in_ch.ready;

  // The winner comes out of the last cell.
  assign best_index = idx_o[QUEUE_DEPTH-1];

  // Row of cells; each sees the registered best of its left neighbor.
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    dlook_pkg::class_t c_in;
    logic [31:0]       k_in;
    logic [IDX_W-1:0]  i_in;
    if (g == 0) begin : g_first
      assign c_in = dlook_pkg::CL_NONE;
      assign k_in = '1;
      assign i_in = '0;
    end else begin : g_rest
      assign c_in = cls_o[g-1];
      assign k_in = key_o[g-1];
      assign i_in = idx_o[g-1];
    end
    assign load_en[g] = accept && in_ch.payload.op == dlook_pkg::OP_ARRIVE &&
                        disk_busy && entry_count == CNT_W'(g);
    assign shift_en[g] = (state == S_REMOVE) && (IDX_W'(g) >= best_index);
    dlook_cell #(.IDX_W(IDX_W)) u_cell (
      .clk       (clk),
      .load      (load_en[g]),
      .load_data (in_req),
      .shift     (shift_en[g]),
      .shift_data(entries[(g + 1) % QUEUE_DEPTH]),
      .occupied  (CNT_W'(g) < entry_count),
      .my_index  (IDX_W'(g)),
      .head      (head),
      .up        (up),
      .in_class  (c_in),
      .in_key    (k_in),
      .in_index  (i_in),
      .out_class (cls_o[g]),
      .out_key   (key_o[g]),
      .out_index (idx_o[g]),
      .entry     (entries[g])
    );
  end

  // Result beat for the current decision.
  always_comb begin
    res_next = '0;
    if (state == S_REMOVE) begin
      res_next.status            = dlook_pkg::ST_NEXT;
      res_next.out_request_id    = entries[best_index].req_tag;
      res_next.out_arrival_time  = entries[best_index].arrival_time;
      res_next.out_cylinder      = entries[best_index].cylinder;
      res_next.out_block_address = entries[best_index].block_address;
      res_next.out_process_id    = entries[best_index].owner_pid;
    end else if (in_ch.payload.op == dlook_pkg::OP_COMPLETE) begin
      res_next.status = dlook_pkg::ST_IDLE;
    end else if (!disk_busy) begin
      res_next.status            = dlook_pkg::ST_DISPATCH;
      res_next.out_request_id    = in_req.req_tag;
      res_next.out_arrival_time  = in_req.arrival_time;
      res_next.out_cylinder      = in_req.cylinder;
      res_next.out_block_address = in_req.block_address;
      res_next.out_process_id    = in_req.owner_pid;
    end else if (entry_count < CNT_W'(QUEUE_DEPTH)) begin
      res_next.status = dlook_pkg::ST_QUEUED;
    end else begin
      res_next.status = dlook_pkg::ST_DROPPED;
    end
  end

  // Control sequencer and output register. The scan state holds until the best
  // beat reaches the last cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      entry_count  <= '0;
      disk_busy    <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (in_ch.payload.op == dlook_pkg::OP_COMPLETE && entry_count != '0) begin
              head  <= in_ch.payload.head_cylinder;
              up    <= in_ch.payload.scan_up;
              step  <= '0;
              state <= S_SCAN;
            end else begin
              out_ch.valid   <= 1'b1;
              out_ch.payload <= res_next;
              if (in_ch.payload.op == dlook_pkg::OP_ARRIVE) begin
                if (!disk_busy) begin
                  disk_busy <= 1'b1;
                end else if (entry_count < CNT_W'(QUEUE_DEPTH)) begin
                  entry_count <= entry_count + 1'b1;
                end
              end else begin
                disk_busy <= 1'b0;
              end
            end
          end
        end
        S_SCAN: begin
          if (step == IDX_W'(QUEUE_DEPTH - 1)) begin
            state <= S_REMOVE;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_REMOVE: begin
          out_ch.valid   <= 1'b1;
          out_ch.payload <= res_next;
          entry_count    <= entry_count - 1'b1;
          disk_busy      <= 1'b1;
          state          <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The table never holds more than its depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count exceeds table depth");

  // A removal always follows a nonempty table.
  a_remove_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_REMOVE |-> entry_count != '0)
    else $error("removal from empty table");

  // The search always finds a candidate when a removal starts.
  a_remove_found: assert property (@(posedge clk) disable iff (rst)
    state == S_REMOVE |-> cls_o[QUEUE_DEPTH-1] != dlook_pkg::CL_NONE)
    else $error("search ended without a candidate");

  // A removal always leaves a result in the output register.
  a_remove_result: assert property (@(posedge clk) disable iff (rst)
    state == S_REMOVE |=> out_ch.valid)
    else $error("removal produced no result");

  // The disk is busy after any chosen result.
  a_busy_after_next: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) && out_ch.payload.status == dlook_pkg::ST_NEXT |-> disk_busy)
    else $error("next chosen while disk idle");

endmodule

### tb/sv/disk_request_look_scheduler_tb.sv
// ----------------------------------------------------------------------------
// disk_request_look_scheduler_tb: self-checking bench for the LOOK scheduler
// A directed pass runs through dispatch, queueing, drops, each pick rule and
// idle completion. Random traffic follows. Every result is compared with a
// model of the pending table, while both sides of the block stall at random.
// ----------------------------------------------------------------------------
module disk_request_look_scheduler_tb;

  localparam int DEPTH      = 16;
  localparam int RAND_ITEMS = 1050;
  localparam int STALL_MAX  = 4;
  localparam int HOLD_LEN   = 400;
  localparam int DRAIN_WAIT = 2 * DEPTH + 8;
  localparam int WDOG_LIMIT = 4000;

  // Pending-table model and the queue of results still owed by the block.
  class look_scoreboard;
    dlook_pkg::request_t pend[$];
    logic                busy;
    dlook_pkg::result_t  owed[$];
    int                  errors;

    function new();
      busy   = 1'b0;
      errors = 0;
    endfunction

    // Apply the LOOK pick rules to the current table.
    function int pick(logic [15:0] head, logic up);
      int  best;
      bit  found;
      best  = 0;
      found = 0;
      // Oldest entry sitting at the head cylinder.
      foreach (pend[i]) begin
        if (pend[i].cylinder == head &&
            (!found || pend[i].arrival_time < pend[best].arrival_time)) begin
          best  = i;
          found = 1;
        end
      end
      if (found) return best;
      // Nearest entry in the scan direction.
      foreach (pend[i]) begin
        if (up ? (pend[i].cylinder > head) : (pend[i].cylinder < head)) begin
          if (!found || (up ? (pend[i].cylinder < pend[best].cylinder)
                            : (pend[i].cylinder > pend[best].cylinder))) begin
            best  = i;
            found = 1;
          end
        end
      end
      if (found) return best;
      // Nearest entry on the far side of the head.
      best = 0;
      for (int i = 1; i < pend.size(); i++) begin
        if (up ? (pend[i].cylinder > pend[best].cylinder)
               : (pend[i].cylinder < pend[best].cylinder))
          best = i;
      end
      return best;
    endfunction

    function void note_beat(dlook_pkg::cmd_t c);
      dlook_pkg::result_t  r;
      dlook_pkg::request_t q;
      int                  k;
      r = '0;
      q.req_tag       = c.in_request_id;
      q.arrival_time  = c.in_arrival_time;
      q.cylinder      = c.in_cylinder;
      q.block_address = c.in_block_address;
      q.owner_pid     = c.in_process_id;
      if (c.op == dlook_pkg::OP_ARRIVE) begin
        if (!busy) begin
          busy = 1'b1;
          r.status            = dlook_pkg::ST_DISPATCH;
          r.out_request_id    = q.req_tag;
          r.out_arrival_time  = q.arrival_time;
          r.out_cylinder      = q.cylinder;
          r.out_block_address = q.block_address;
          r.out_process_id    = q.owner_pid;
        end else if (pend.size() < DEPTH) begin
          pend.push_back(q);
          r.status = dlook_pkg::ST_QUEUED;
        end else begin
          r.status = dlook_pkg::ST_DROPPED;
        end
      end else if (pend.size() == 0) begin
        busy = 1'b0;
        r.status = dlook_pkg::ST_IDLE;
      end else begin
        k = pick(c.head_cylinder, c.scan_up);
        r.status            = dlook_pkg::ST_NEXT;
        r.out_request_id    = pend[k].req_tag;
        r.out_arrival_time  = pend[k].arrival_time;
        r.out_cylinder      = pend[k].cylinder;
        r.out_block_address = pend[k].block_address;
        r.out_process_id    = pend[k].owner_pid;
        pend.delete(k);
        busy = 1'b1;
      end
      owed.push_back(r);
    endfunction

    function void check_result(dlook_pkg::result_t a);
      dlook_pkg::result_t e;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result, actual %p", $time, a);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (a.status != e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, a.status);
        errors++;
      end
      if (a.out_request_id != e.out_request_id) begin
        $display("%0t: out_request_id expected %h actual %h", $time,
                 e.out_request_id, a.out_request_id);
        errors++;
      end
      if (a.out_arrival_time != e.out_arrival_time) begin
        $display("%0t: arrival_time expected %h actual %h", $time,
                 e.out_arrival_time, a.out_arrival_time);
        errors++;
      end
      if (a.out_cylinder != e.out_cylinder) begin
        $display("%0t: cylinder expected %h actual %h", $time,
                 e.out_cylinder, a.out_cylinder);
        errors++;
      end
      if (a.out_block_address != e.out_block_address) begin
        $display("%0t: block_address expected %h actual %h", $time,
                 e.out_block_address, a.out_block_address);
        errors++;
      end
      if (a.out_process_id != e.out_process_id) begin
        $display("%0t: out_process_id expected %h actual %h", $time,
                 e.out_process_id, a.out_process_id);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   hold_off = 0;
  int   idle_cycles = 0;

  dlook_if #(.payload_t(dlook_pkg::cmd_t))    in_ch ();
  dlook_if #(.payload_t(dlook_pkg::result_t)) out_ch ();

  look_scoreboard sb = new();

  disk_request_look_scheduler #(.QUEUE_DEPTH(DEPTH)) uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    out_ch.ready  = 1'b0;
  end

  // Cylinders and times cluster on a few values so that ties come often.
  function automatic logic [15:0] pick_cyl();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom);
      default: return 16'($urandom_range(0, 15));
    endcase
  endfunction

  // Every field filled with random bits.
  function automatic dlook_pkg::cmd_t rand_cmd();
    dlook_pkg::cmd_t c;
    c.op               = $urandom_range(0, 1) ? dlook_pkg::OP_COMPLETE
                                              : dlook_pkg::OP_ARRIVE;
    c.in_request_id    = 16'($urandom);
    c.in_arrival_time  = $urandom;
    c.in_cylinder      = 16'($urandom);
    c.in_block_address = $urandom;
    c.in_process_id    = 16'($urandom);
    c.head_cylinder    = 16'($urandom);
    c.scan_up          = 1'($urandom);
    return c;
  endfunction

  function automatic dlook_pkg::cmd_t make_cmd(int arrive_pct);
    dlook_pkg::cmd_t c;
    c = rand_cmd();
    c.op            = ($urandom_range(1, 100) <= arrive_pct) ? dlook_pkg::OP_ARRIVE
                                                             : dlook_pkg::OP_COMPLETE;
    c.in_cylinder   = pick_cyl();
    c.head_cylinder = pick_cyl();
    if ($urandom_range(0, 1)) c.in_arrival_time = $urandom_range(0, 3);
    return c;
  endfunction

  function automatic dlook_pkg::cmd_t arrive(logic [15:0] id, logic [31:0] tm,
                                             logic [15:0] cyl);
    dlook_pkg::cmd_t c;
    c = '0;
    c.op               = dlook_pkg::OP_ARRIVE;
    c.in_request_id    = id;
    c.in_arrival_time  = tm;
    c.in_cylinder      = cyl;
    c.in_block_address = {id, ~id};
    c.in_process_id    = ~id;
    return c;
  endfunction

  function automatic dlook_pkg::cmd_t complete(logic [15:0] head, logic up);
    dlook_pkg::cmd_t c;
    c = rand_cmd();
    c.op            = dlook_pkg::OP_COMPLETE;
    c.head_cylinder = head;
    c.scan_up       = up;
    return c;
  endfunction

  // Offer one beat after a random gap and hold it until the block takes it.
  task automatic send(dlook_pkg::cmd_t c);
    int gap;
    gap = $urandom_range(0, STALL_MAX);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= c;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_beat(c);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int stall;
    @(posedge clk iff !rst);
    forever begin
      stall = hold_off ? HOLD_LEN : $urandom_range(0, STALL_MAX);
      if (hold_off) hold_off = 0;
      else if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      sb.check_result(out_ch.payload);
    end
  end

  // Watchdog on cycles with no beat on either side.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("%0t: watchdog timeout", $time);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int pct;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: idle completion, all-zero dispatch, extreme fields.
    send(complete(16'h0000, 1'b0));
    send(arrive(16'h0000, 32'h0, 16'h0000));
    send(arrive(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF));
    send(arrive(16'h0011, 32'h5, 16'h0008));
    send(arrive(16'h0012, 32'h3, 16'h0008));
    send(arrive(16'h0013, 32'h3, 16'h0008));
    send(arrive(16'h0014, 32'h1, 16'h0002));
    send(arrive(16'h0015, 32'h1, 16'h000C));
    // Head match picks the oldest, equal times go to the earlier entry.
    send(complete(16'h0008, 1'b1));
    // Scan up, scan down and up again, then nothing ahead so the far side wins.
    send(complete(16'h0009, 1'b1));
    send(complete(16'h0009, 1'b0));
    send(complete(16'hFFFE, 1'b1));
    send(complete(16'h0001, 1'b0));
    send(complete(16'h0001, 1'b0));
    send(complete(16'h0001, 1'b0));
    // Empty table idles the disk; refill past the depth so arrivals drop, then pick.
    send(complete(16'h0001, 1'b0));
    send(arrive(16'h0100, 32'h9, 16'h0040));
    for (int i = 0; i < DEPTH + 2; i++)
      send(arrive(16'(16'h0200 + i), 32'(i), 16'(i * 3)));
    send(complete(16'h0007, 1'b0));
    wait_drained();

    // Random traffic with shifting arrival rates.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: pct = 80;
          1: pct = 55;
          default: pct = 35;
        endcase
      end
      if (n == 300) hold_off = 1;
      if (n == 650) wait_drained();
      send(make_cmd(pct));
    end

    wait_drained();
    if (sb.errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
